/* src/cda_pkg.sv */
package cda_pkg;

   // Field widths of one word on each channel.
   localparam int ACTION_W = 3;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD = 3'd0,
      ACT_NEXT = 3'd1,
      ACT_PREV = 3'd2,
      ACT_ADD  = 3'd3,
      ACT_SUB  = 3'd4
   } action_type;

   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [YEAR_W-1:0]  year_type;

   // Working values during an offset: the day spans -30 to 62 and the month -14 to 27.
   typedef logic signed [DAY_W+1:0]   day_work_type;
   typedef logic signed [MONTH_W+1:0] month_work_type;

   localparam month_type MONTH_JAN = 4'd1;
   localparam month_type MONTH_FEB = 4'd2;
   localparam month_type MONTH_APR = 4'd4;
   localparam month_type MONTH_JUN = 4'd6;
   localparam month_type MONTH_SEP = 4'd9;
   localparam month_type MONTH_NOV = 4'd11;
   localparam month_type MONTH_DEC = 4'd12;

   localparam day_type DAY_FIRST     = 5'd1;
   localparam day_type DAYS_FEB      = 5'd28;
   localparam day_type DAYS_LEAP_FEB = 5'd29;
   localparam day_type DAYS_SHORT    = 5'd30;
   localparam day_type DAYS_LONG     = 5'd31;

   localparam day_work_type   DAY_STEP   = 7'sd1;
   localparam month_work_type MONTH_STEP = 6'sd1;
   localparam month_work_type MONTH_SPAN = 6'sd12;

   localparam year_type YEAR_RESET = 16'd1900;
   localparam year_type YEAR_ONE   = 16'd1;

   // A year is a multiple of 25 when year * inverse(25) mod 2^16 lands at or below 65535 / 25.
   localparam year_type YEAR_INV25   = 16'd23593;
   localparam year_type YEAR_Q25_MAX = 16'd2621;

   typedef enum logic [1:0] {
      STEP_CARRY,
      STEP_WRAP,
      STEP_YEAR
   } step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic          sub;
      logic          next;
   } step_ctl_type;

   typedef struct packed {
      day_work_type   day;
      month_work_type month;
      year_type       year;
      logic           hit;
      logic           wrap;
   } step_res_type;

   // Number of days in a month, given whether the year is a leap year.
   function automatic day_type month_len(input month_type month, input logic leap);
      day_type len;
      if (month == MONTH_FEB) begin
         len = leap ? DAYS_LEAP_FEB : DAYS_FEB;
      end else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
         len = DAYS_SHORT;
      end else begin
         len = DAYS_LONG;
      end
      return len;
   endfunction

endpackage

/* src/cda_if.sv */
// Request channel: one action with its operands per word.
interface cda_req_if;
   logic                         valid;
   logic                         ready;
   logic [cda_pkg::ACTION_W-1:0] action;
   logic [cda_pkg::DAY_W-1:0]    operand_day;
   logic [cda_pkg::MONTH_W-1:0]  operand_month;
   logic [cda_pkg::YEAR_W-1:0]   operand_year;

   modport source (output valid, action, operand_day, operand_month, operand_year,
                   input ready);
   modport sink (input valid, action, operand_day, operand_month, operand_year,
                 output ready);
endinterface

// Response channel: the date after the action.
interface cda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cda_pkg::DAY_W-1:0]   day_out;
   logic [cda_pkg::MONTH_W-1:0] month_out;
   logic [cda_pkg::YEAR_W-1:0]  year_out;
   logic                        leap_year;
   logic                        year_wrapped;

   modport source (output valid, day_out, month_out, year_out, leap_year, year_wrapped,
                   input ready);
   modport sink (input valid, day_out, month_out, year_out, leap_year, year_wrapped,
                 output ready);
endinterface

/* src/cda_leap.sv */
module cda_leap (
   input  cda_pkg::year_type year,
   output logic              leap
);
   import cda_pkg::*;

   year_type prod;
   logic     by4;
   logic     by16;
   logic     by25;

   // Divisibility by 25 through the modular inverse, by 4 and 16 from the low bits.
   assign prod = year * YEAR_INV25;
   assign by25 = (prod <= YEAR_Q25_MAX);
   assign by4  = (year[1:0] == 2'b00);
   assign by16 = (year[3:0] == 4'b0000);

   // Divisible by 4 and not by 100, or divisible by 400.
   assign leap = by4 && (!by25 || by16);

endmodule

/* src/cda_step.sv */
module cda_step (
   input  cda_pkg::step_ctl_type   ctl,
   input  cda_pkg::day_work_type   day,
   input  cda_pkg::month_work_type month,
   input  cda_pkg::year_type       year,
   input  logic                    leap,
   input  cda_pkg::year_type       year_opnd,
   output cda_pkg::step_res_type   res
);
   import cda_pkg::*;

   year_type         yop;
   logic [YEAR_W:0]  ysum;
   month_type        mnum;
   month_type        mprev;
   day_type          len;
   day_work_type     len_w;

   // The one year adder: plus or minus one for a carry, or the year offset.
   assign yop  = (ctl.kind == STEP_YEAR) ? year_opnd : YEAR_ONE;
   assign ysum = ctl.sub ? ({1'b0, year} - {1'b0, yop}) : ({1'b0, year} + {1'b0, yop});

   // Going forward the current month's length is removed, going back the previous one's added.
   assign mnum  = month[MONTH_W-1:0];
   assign mprev = (mnum == MONTH_JAN) ? MONTH_DEC : (mnum - MONTH_JAN);
   assign len   = month_len(ctl.sub ? mprev : mnum, leap);
   assign len_w = day_work_type'({2'b00, len});

   always_comb begin
      res.day   = day;
      res.month = month;
      res.year  = year;
      res.hit   = 1'b0;
      res.wrap  = 1'b0;
      case (ctl.kind)
         STEP_CARRY: begin
            if (!ctl.sub) begin
               // Day past the month end: move into the next month.
               if (day > len_w) begin
                  res.hit = 1'b1;
                  res.day = ctl.next ? day_work_type'({2'b00, DAY_FIRST}) : (day - len_w);
                  if (mnum == MONTH_DEC) begin
                     res.month = month_work_type'({2'b00, MONTH_JAN});
                     res.year  = ysum[YEAR_W-1:0];
                     res.wrap  = ysum[YEAR_W];
                  end else begin
                     res.month = month + MONTH_STEP;
                  end
               end
            end else begin
               // Day below the first: borrow the previous month.
               if (day < DAY_STEP) begin
                  res.hit = 1'b1;
                  res.day = day + len_w;
                  if (mnum == MONTH_JAN) begin
                     res.month = month_work_type'({2'b00, MONTH_DEC});
                     res.year  = ysum[YEAR_W-1:0];
                     res.wrap  = ysum[YEAR_W];
                  end else begin
                     res.month = month - MONTH_STEP;
                  end
               end
            end
         end
         STEP_WRAP: begin
            // Month outside one to twelve: fold a year in or out.
            if (!ctl.sub && (month > MONTH_SPAN)) begin
               res.hit   = 1'b1;
               res.month = month - MONTH_SPAN;
               res.year  = ysum[YEAR_W-1:0];
               res.wrap  = ysum[YEAR_W];
            end else if (ctl.sub && (month < MONTH_STEP)) begin
               res.hit   = 1'b1;
               res.month = month + MONTH_SPAN;
               res.year  = ysum[YEAR_W-1:0];
               res.wrap  = ysum[YEAR_W];
            end
         end
         STEP_YEAR: begin
            res.hit  = 1'b1;
            res.year = ysum[YEAR_W-1:0];
            res.wrap = ysum[YEAR_W];
         end
         default: begin
            res.hit = 1'b0;
         end
      endcase
   end

endmodule

/* src/calendar_date_adjuster_unit.sv */
// Gregorian date counter. The unit holds one date (day, month, year, reset to 1 Jan 1900) and
// applies one action per request word: load, next day, previous day, or add or subtract a
// day, month and year offset, with days carried first, then months folded into years, then
// the year offset applied; the day is not clamped after a month change, and the year wraps
// modulo 65536 with year_wrapped set. A load passes through the leap test to the output state,
// an unknown action goes straight to the output state, and the other actions pass through the
// day carry, month fold, year and leap states before the result is in the output register:
// the shared step unit resolves one month carry, one year fold or the year offset per cycle,
// and a day carry and a month fold each take at most two such steps. A last state tests the
// leap rule on the new year. Requests are taken only while the sequencer is idle; a finished
// response waits in the output register while the next request is being worked.
module calendar_date_adjuster_unit (
   input  logic      clock,
   input  logic      reset,
   cda_req_if.sink   req_bus,
   cda_rsp_if.source rsp_bus
);
   import cda_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CARRY,
      ST_MONTH,
      ST_YEAR,
      ST_LEAP,
      ST_OUT
   } state_type;

   state_type      state_ff, state_in;
   day_work_type   day_ff, day_in;
   month_work_type month_ff, month_in;
   year_type       year_ff, year_in;
   logic           leap_ff, leap_in;
   logic           wrap_ff, wrap_in;
   logic           sub_ff, sub_in;
   logic           next_ff, next_in;
   month_type      om_ff, om_in;
   year_type       oy_ff, oy_in;
   logic           rsp_valid_ff, rsp_valid_in;
   day_type        rsp_day_ff, rsp_day_in;
   month_type      rsp_month_ff, rsp_month_in;
   year_type       rsp_year_ff, rsp_year_in;
   logic           rsp_leap_ff, rsp_leap_in;
   logic           rsp_wrap_ff, rsp_wrap_in;

   step_ctl_type   step_ctl;
   step_res_type   step_res;
   logic           year_leap;

   // Shared step unit and leap test of the held year.
   cda_step u_step (
      .ctl       (step_ctl),
      .day       (day_ff),
      .month     (month_ff),
      .year      (year_ff),
      .leap      (leap_ff),
      .year_opnd (oy_ff),
      .res       (step_res)
   );

   cda_leap u_leap (
      .year (year_ff),
      .leap (year_leap)
   );

   // Step unit operation follows the sequencer state.
   always_comb begin
      step_ctl.sub  = sub_ff;
      step_ctl.next = next_ff;
      case (state_ff)
         ST_CARRY: step_ctl.kind = STEP_CARRY;
         ST_MONTH: step_ctl.kind = STEP_WRAP;
         default:  step_ctl.kind = STEP_YEAR;
      endcase
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.day_out      = rsp_day_ff;
   assign rsp_bus.month_out    = rsp_month_ff;
   assign rsp_bus.year_out     = rsp_year_ff;
   assign rsp_bus.leap_year    = rsp_leap_ff;
   assign rsp_bus.year_wrapped = rsp_wrap_ff;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      leap_in      = leap_ff;
      wrap_in      = wrap_ff;
      sub_in       = sub_ff;
      next_in      = next_ff;
      om_in        = om_ff;
      oy_in        = oy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_leap_in  = rsp_leap_ff;
      rsp_wrap_in  = rsp_wrap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               wrap_in  = 1'b0;
               next_in  = 1'b0;
               sub_in   = 1'b0;
               om_in    = '0;
               oy_in    = '0;
               state_in = ST_CARRY;
               case (req_bus.action)
                  ACT_LOAD: begin
                     // Day zero reads as the first, month is clamped to one through twelve.
                     if (req_bus.operand_day == '0) begin
                        day_in = day_work_type'({2'b00, DAY_FIRST});
                     end else begin
                        day_in = day_work_type'({2'b00, req_bus.operand_day});
                     end
                     if (req_bus.operand_month == '0) begin
                        month_in = month_work_type'({2'b00, MONTH_JAN});
                     end else if (req_bus.operand_month > MONTH_DEC) begin
                        month_in = month_work_type'({2'b00, MONTH_DEC});
                     end else begin
                        month_in = month_work_type'({2'b00, req_bus.operand_month});
                     end
                     year_in  = req_bus.operand_year;
                     state_in = ST_LEAP;
                  end
                  ACT_NEXT: begin
                     day_in  = day_ff + DAY_STEP;
                     next_in = 1'b1;
                  end
                  ACT_PREV: begin
                     day_in = day_ff - DAY_STEP;
                     sub_in = 1'b1;
                  end
                  ACT_ADD: begin
                     day_in = day_ff + {2'b00, req_bus.operand_day};
                     om_in  = req_bus.operand_month;
                     oy_in  = req_bus.operand_year;
                  end
                  ACT_SUB: begin
                     day_in = day_ff - {2'b00, req_bus.operand_day};
                     om_in  = req_bus.operand_month;
                     oy_in  = req_bus.operand_year;
                     sub_in = 1'b1;
                  end
                  default: begin
                     // Unknown action: report the date as it stands.
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_CARRY: begin
            if (step_res.hit) begin
               day_in   = step_res.day;
               month_in = step_res.month;
               year_in  = step_res.year;
               wrap_in  = wrap_ff | step_res.wrap;
            end else begin
               // Days settled: apply the month offset.
               month_in = sub_ff ? (month_ff - {2'b00, om_ff}) : (month_ff + {2'b00, om_ff});
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (step_res.hit) begin
               month_in = step_res.month;
               year_in  = step_res.year;
               wrap_in  = wrap_ff | step_res.wrap;
            end else begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            year_in  = step_res.year;
            wrap_in  = wrap_ff | step_res.wrap;
            state_in = ST_LEAP;
         end
         ST_LEAP: begin
            leap_in  = year_leap;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = day_ff[DAY_W-1:0];
               rsp_month_in = month_ff[MONTH_W-1:0];
               rsp_year_in  = year_ff;
               rsp_leap_in  = leap_ff;
               rsp_wrap_in  = wrap_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= day_work_type'({2'b00, DAY_FIRST});
         month_ff     <= month_work_type'({2'b00, MONTH_JAN});
         year_ff      <= YEAR_RESET;
         leap_ff      <= 1'b0;
         wrap_ff      <= 1'b0;
         sub_ff       <= 1'b0;
         next_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         leap_ff      <= leap_in;
         wrap_ff      <= wrap_in;
         sub_ff       <= sub_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      om_ff        <= om_in;
      oy_ff        <= oy_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_leap_ff  <= rsp_leap_in;
      rsp_wrap_ff  <= rsp_wrap_in;
   end

   // A response word only appears out of the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   // The held date is a real day and month between actions.
   a_idle_date_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (month_ff >= MONTH_STEP && month_ff <= MONTH_SPAN &&
                                 day_ff >= DAY_STEP &&
                                 day_ff <= day_work_type'({2'b00, DAYS_LONG})))
      else $error("held date out of range");

   // The leap flag used by the day carry belongs to the held year.
   a_leap_tracks_year: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (leap_ff == year_leap))
      else $error("leap flag stale");

   // A day carry settles within two month steps.
   a_carry_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CARRY) |-> ##3 (state_ff != ST_CARRY))
      else $error("day carry did not settle");

   // A month fold settles within two year steps.
   a_month_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> ##3 (state_ff != ST_MONTH))
      else $error("month fold did not settle");

endmodule
